// ----- hw/rtl/irm_pkg.sv -----
// Shared types and constants for the interval range map.
// Used by the channel interfaces, the breakpoint table and the top level.
package irm_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 8;
  localparam int STAT_W   = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0]        val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [STAT_W-1:0]       stat_t;

  localparam logic  CMD_ASSIGN = 1'b0;
  localparam logic  CMD_LOOKUP = 1'b1;

  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_EMPTY = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;

  typedef struct packed {
    key_t key;
    val_t val;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } tbl_req_t;

endpackage

// ----- hw/rtl/irm_in_if.sv -----
// Input channel of the interval range map: valid/ready plus one command.
// Depends on irm_pkg.
interface irm_in_if import irm_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  key_t range_begin;
  key_t range_end;
  val_t new_value;
  key_t lookup_key;

  modport source (output valid, output cmd, output range_begin, output range_end,
                  output new_value, output lookup_key, input ready);
  modport sink   (input valid, input cmd, input range_begin, input range_end,
                  input new_value, input lookup_key, output ready);
endinterface

// ----- hw/rtl/irm_out_if.sv -----
// Result channel of the interval range map: valid/ready plus one result.
// Depends on irm_pkg.
interface irm_out_if import irm_pkg::*; ();
  logic  valid;
  logic  ready;
  val_t  mapped_value;
  stat_t status;
  cnt_t  entry_count;

  modport source (output valid, output mapped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input mapped_value, input status,
                  input entry_count, output ready);
endinterface

// ----- hw/rtl/interval_range_map.sv -----
// Top level of the interval range map: sequencer, compare logic and result register.
// Depends on irm_pkg, irm_in_if, irm_out_if and irm_table.
//
//   port     dir  handshake          carries
//   in_ch    in   valid/ready        cmd, range_begin, range_end, new_value, lookup_key
//   out_ch   out  valid/ready        mapped_value, status, entry_count
//   cfg_*    in   cfg_we, no stall   default_value on cfg_wdata
//
// One transaction at a time; in_ch.ready is high only while the sequencer is idle.
// Lookup: scan the breakpoints at or below the key, then S_PLAN, then the result.
// Assign: the same scan up to the range end, S_PLAN to pick the boundary entries and
// check capacity, S_MOVE to shift the breakpoints above the range, and S_INS to write
// the boundary entries. Table full: scan, S_PLAN, result. Empty range: straight to S_DONE.
// All of it is paced by the single read port of the breakpoint table.
// Synchronous active-low reset empties the table and clears default_value.
// A result waits in the output register while out_ch.ready is low.
module interval_range_map import irm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  val_t      cfg_wdata,
  irm_in_if.sink    in_ch,
  irm_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_PLAN = 6'b000100,
    S_MOVE = 6'b001000,
    S_INS  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // control state
  state_t state_r, state_nxt;
  val_t   dflt_r, dflt_nxt;
  cnt_t   used_r, used_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;

  // working registers
  logic   cmd_r, cmd_nxt;
  key_t   b_r, b_nxt;
  key_t   e_r, e_nxt;
  val_t   v_r, v_nxt;
  cnt_t   lo_r, lo_nxt;
  cnt_t   hi_r, hi_nxt;
  val_t   prev_r, prev_nxt;
  val_t   endv_r, endv_nxt;
  cnt_t   iss_r, iss_nxt;
  cnt_t   src_r, src_nxt;
  cnt_t   psrc_r, psrc_nxt;
  cnt_t   rem_r, rem_nxt;
  cnt_t   dist_r, dist_nxt;
  logic   up_r, up_nxt;
  logic   ins0_r, ins0_nxt;
  logic   ins1_r, ins1_nxt;
  logic   step_r, step_nxt;
  cnt_t   n_r, n_nxt;
  val_t   res_val_r, res_val_nxt;
  stat_t  res_stat_r, res_stat_nxt;
  val_t   out_val_r, out_val_nxt;
  stat_t  out_stat_r, out_stat_nxt;
  cnt_t   out_cnt_r, out_cnt_nxt;

  tbl_req_t req;
  entry_t   rd_data;

  logic           lt_b, le_e, stop, issue, out_load;
  logic [CNT_W:0] base_w, n_w;
  cnt_t           tail, dst;

  irm_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // shared compare unit: one table entry against the range bounds
  assign lt_b = $signed(rd_data.key) <  $signed(b_r);
  assign le_e = $signed(rd_data.key) <= $signed(e_r);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped_value = out_val_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.entry_count  = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    dflt_nxt      = cfg_we ? cfg_wdata : dflt_r;
    used_nxt      = used_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    v_nxt         = v_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    prev_nxt      = prev_r;
    endv_nxt      = endv_r;
    iss_nxt       = iss_r;
    src_nxt       = src_r;
    psrc_nxt      = psrc_r;
    rem_nxt       = rem_r;
    dist_nxt      = dist_r;
    up_nxt        = up_r;
    ins0_nxt      = ins0_r;
    ins1_nxt      = ins1_r;
    step_nxt      = step_r;
    n_nxt         = n_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    req           = '0;
    stop          = 1'b0;
    issue         = 1'b0;
    out_load      = 1'b0;
    base_w        = {1'b0, lo_r} + {{CNT_W{1'b0}}, ins0_r} + {{CNT_W{1'b0}}, ins1_r};
    tail          = used_r - hi_r;
    n_w           = base_w + {1'b0, tail};
    dst           = up_r ? psrc_r + dist_r : psrc_r - dist_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt     = in_ch.cmd;
          b_nxt       = in_ch.range_begin;
          e_nxt       = (in_ch.cmd == CMD_LOOKUP) ? in_ch.lookup_key : in_ch.range_end;
          v_nxt       = in_ch.new_value;
          lo_nxt      = '0;
          hi_nxt      = '0;
          prev_nxt    = dflt_r;
          endv_nxt    = dflt_r;
          iss_nxt     = '0;
          res_val_nxt = '0;
          if (in_ch.cmd == CMD_ASSIGN &&
              !($signed(in_ch.range_begin) < $signed(in_ch.range_end))) begin
            res_stat_nxt = ST_EMPTY;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // evaluate the entry read last cycle; stop at the first key above the range
        if (pend_r) begin
          if (le_e) begin
            hi_nxt   = hi_r + cnt_t'(1);
            endv_nxt = rd_data.val;
          end else begin
            stop = 1'b1;
          end
          if (lt_b) begin
            lo_nxt   = lo_r + cnt_t'(1);
            prev_nxt = rd_data.val;
          end
        end
        issue = !stop && (iss_r < used_r);
        if (issue) begin
          req.rd_en   = 1'b1;
          req.rd_addr = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + cnt_t'(1);
          pend_nxt    = 1'b1;
        end else begin
          state_nxt = S_PLAN;
        end
      end

      S_PLAN: begin
        if (cmd_r == CMD_LOOKUP) begin
          res_val_nxt  = endv_r;
          res_stat_nxt = ST_OK;
          state_nxt    = S_DONE;
        end else if (step_r == 1'b0) begin
          // first plan cycle: decide which boundary entries are needed
          ins0_nxt = (v_r != prev_r);
          ins1_nxt = (endv_r != v_r);
          step_nxt = 1'b1;
        end else begin
          step_nxt = 1'b0;
          if (n_w > (CNT_W+1)'(CAPACITY)) begin
            res_stat_nxt = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            n_nxt     = cnt_t'(n_w);
            up_nxt    = base_w > {1'b0, hi_r};
            dist_nxt  = (base_w > {1'b0, hi_r}) ? cnt_t'(base_w - {1'b0, hi_r})
                                                : cnt_t'({1'b0, hi_r} - base_w);
            rem_nxt   = (base_w == {1'b0, hi_r}) ? '0 : tail;
            src_nxt   = (base_w > {1'b0, hi_r}) ? used_r - cnt_t'(1) : hi_r;
            state_nxt = S_MOVE;
          end
        end
      end

      S_MOVE: begin
        // shift the tail: top down when it grows, bottom up when it shrinks
        if (pend_r) begin
          req.wr_en   = 1'b1;
          req.wr_addr = dst[IDX_W-1:0];
          req.wr_data = rd_data;
        end
        if (rem_r != '0) begin
          req.rd_en   = 1'b1;
          req.rd_addr = src_r[IDX_W-1:0];
          psrc_nxt    = src_r;
          src_nxt     = up_r ? src_r - cnt_t'(1) : src_r + cnt_t'(1);
          rem_nxt     = rem_r - cnt_t'(1);
          pend_nxt    = 1'b1;
        end else begin
          step_nxt  = 1'b0;
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        if (step_r == 1'b0) begin
          req.wr_en   = ins0_r;
          req.wr_addr = lo_r[IDX_W-1:0];
          req.wr_data = '{key: b_r, val: v_r};
          step_nxt    = 1'b1;
        end else begin
          req.wr_en    = ins1_r;
          req.wr_addr  = idx_t'(lo_r + cnt_t'(ins0_r));
          req.wr_data  = '{key: e_r, val: endv_r};
          step_nxt     = 1'b0;
          used_nxt     = n_r;
          res_stat_nxt = ST_OK;
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_stat_nxt  = res_stat_r;
          out_cnt_nxt   = used_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dflt_r      <= '0;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dflt_r      <= dflt_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    v_r        <= v_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    prev_r     <= prev_nxt;
    endv_r     <= endv_nxt;
    iss_r      <= iss_nxt;
    src_r      <= src_nxt;
    psrc_r     <= psrc_nxt;
    rem_r      <= rem_nxt;
    dist_r     <= dist_nxt;
    up_r       <= up_nxt;
    ins0_r     <= ins0_nxt;
    ins1_r     <= ins1_nxt;
    n_r        <= n_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

endmodule

// ----- hw/rtl/irm_table.sv -----
// Breakpoint table: CAPACITY entries of (key, value), one write and one read
// port, read data registered. Depends on irm_pkg.
module irm_table import irm_pkg::*; (
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/sv/interval_range_map_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for interval_range_map: range assigns and lookups
// against a breakpoint-table predictor. Depends on irm_pkg, irm_in_if, irm_out_if.
module interval_range_map_tb;
  import irm_pkg::*;

  localparam int   CLK_PERIOD = 10;
  localparam int   LONG_HOLD  = 400;
  localparam int   NUM_PHASES = 12;
  localparam int   PHASE_ITEMS = 127;
  localparam int   FILL_ITEMS = 36;
  localparam longint TIMEOUT_NS = 64'd40_000_000;
  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct {
    logic cmd;
    key_t range_begin;
    key_t range_end;
    val_t new_value;
    key_t lookup_key;
  } map_req_t;

  typedef struct {
    val_t  mapped_value;
    stat_t status;
    cnt_t  entry_count;
  } map_resp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  val_t cfg_wdata;

  irm_in_if  in_ch();
  irm_out_if out_ch();

  interval_range_map dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: sorted breakpoints plus the default value.
  key_t bp_key [CAPACITY];
  val_t bp_val [CAPACITY];
  int   bp_count = 0;
  val_t dflt_value = '0;

  map_req_t  pending_reqs[$];
  map_resp_t predicted_results[$];
  map_req_t  cur_req;

  bit idle_on = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int err_count = 0;
  int results_checked = 0;
  int n_lookup = 0, n_assign = 0, n_empty = 0, n_full = 0, cfg_writes = 0;

  function automatic val_t map_value_at(key_t k);
    val_t v;
    int i;
    v = dflt_value;
    for (i = 0; i < bp_count; i++) begin
      if (bp_key[i] > k) break;
      v = bp_val[i];
    end
    return v;
  endfunction

  // Apply one transaction to the breakpoint table and return its result.
  function automatic map_resp_t map_apply(map_req_t rq);
    map_resp_t rs;
    key_t nk [CAPACITY+2];
    val_t nv [CAPACITY+2];
    int n, i;
    val_t prev, end_val;
    bit overflow;
    rs.mapped_value = '0;
    rs.status = ST_OK;
    n = 0;
    overflow = 1'b0;
    if (rq.cmd == CMD_LOOKUP) begin
      rs.mapped_value = map_value_at(rq.lookup_key);
    end else if (rq.range_begin >= rq.range_end) begin
      rs.status = ST_EMPTY;
    end else begin
      end_val = map_value_at(rq.range_end);
      prev = dflt_value;
      i = 0;
      while (i < bp_count && bp_key[i] < rq.range_begin) begin
        nk[n] = bp_key[i];
        nv[n] = bp_val[i];
        prev = bp_val[i];
        n++;
        i++;
      end
      if (rq.new_value != prev) begin
        nk[n] = rq.range_begin;
        nv[n] = rq.new_value;
        n++;
      end
      if (end_val != rq.new_value) begin
        nk[n] = rq.range_end;
        nv[n] = end_val;
        n++;
      end
      // Keep breakpoints strictly above the range; drop the rest.
      for (; i < bp_count; i++) begin
        if (bp_key[i] > rq.range_end) begin
          if (n >= CAPACITY + 2) begin
            overflow = 1'b1;
          end else begin
            nk[n] = bp_key[i];
            nv[n] = bp_val[i];
            n++;
          end
        end
      end
      if (overflow || n > CAPACITY) begin
        rs.status = ST_FULL;
      end else begin
        for (i = 0; i < n; i++) begin
          bp_key[i] = nk[i];
          bp_val[i] = nv[i];
        end
        bp_count = n;
      end
    end
    rs.entry_count = cnt_t'(bp_count);
    return rs;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic int receiver_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic key_t pick_key(int w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return KEY_MAX;
        default: return KEY_MAX - 1;
      endcase
    end
    if (r < 10) return key_t'($urandom);
    return key_t'(int'($urandom_range(0, 2 * w)) - w);
  endfunction

  function automatic val_t pick_value();
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: return dflt_value;
        1: return val_t'(1);
        2: return val_t'(2);
        default: return val_t'(3);
      endcase
    end
    return val_t'($urandom_range(0, 255));
  endfunction

  function automatic map_req_t random_req(int w);
    map_req_t rq;
    longint e_l;
    rq.cmd = ($urandom_range(0, 99) < 40) ? CMD_LOOKUP : CMD_ASSIGN;
    rq.lookup_key = pick_key(w);
    rq.range_begin = pick_key(w);
    rq.new_value = pick_value();
    if ($urandom_range(0, 99) < 8) begin
      rq.range_end = pick_key(w);
    end else begin
      e_l = longint'(rq.range_begin) + longint'($urandom_range(1, w));
      if (e_l > longint'(KEY_MAX)) e_l = longint'(KEY_MAX);
      rq.range_end = key_t'(e_l);
    end
    return rq;
  endfunction

  task automatic push_assign(key_t b, key_t e, val_t v);
    map_req_t rq;
    rq.cmd = CMD_ASSIGN;
    rq.range_begin = b;
    rq.range_end = e;
    rq.new_value = v;
    rq.lookup_key = key_t'($urandom);
    pending_reqs.push_back(rq);
  endtask

  task automatic push_lookup(key_t k);
    map_req_t rq;
    rq.cmd = CMD_LOOKUP;
    rq.range_begin = key_t'($urandom);
    rq.range_end = key_t'($urandom);
    rq.new_value = val_t'($urandom);
    rq.lookup_key = k;
    pending_reqs.push_back(rq);
  endtask

  // Hold until every queued transaction is sent and answered.
  // Sample away from the rising edge so the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default(val_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_value = v;
    cfg_writes++;
  endtask

  // Driver: predict on each accepted transaction, then load the next one.
  always @(posedge clk) begin
    map_resp_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r = map_apply(cur_req);
        predicted_results.push_back(r);
        if (cur_req.cmd == CMD_LOOKUP) n_lookup++;
        else n_assign++;
        if (r.status == ST_EMPTY) n_empty++;
        if (r.status == ST_FULL) n_full++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= cur_req.cmd;
          in_ch.range_begin <= cur_req.range_begin;
          in_ch.range_end <= cur_req.range_end;
          in_ch.new_value <= cur_req.new_value;
          in_ch.lookup_key <= cur_req.lookup_key;
          send_gap <= sender_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and pace out_ch.ready.
  always @(posedge clk) begin
    map_resp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected transaction: mapped_value %0d status %0d entry_count %0d",
                 out_ch.mapped_value, out_ch.status, out_ch.entry_count);
          err_count++;
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          if (out_ch.mapped_value !== want.mapped_value) begin
            $error("mapped_value: expected %0d, got %0d", want.mapped_value,
                   out_ch.mapped_value);
            err_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            err_count++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            err_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        recv_stall <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        recv_stall <= receiver_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int p, k, wnd, base, stride;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ASSIGN;
    in_ch.range_begin = '0;
    in_ch.range_end = '0;
    in_ch.new_value = '0;
    in_ch.lookup_key = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    write_default(8'h5A);
    // Empty table, empty ranges, full-span assign and merges of equal neighbors.
    push_lookup(KEY_MIN);
    push_lookup(KEY_MAX);
    push_assign(7, 7, 8'd1);
    push_assign(10, 3, 8'd2);
    push_assign(KEY_MAX, KEY_MIN, 8'd3);
    push_assign(KEY_MIN, KEY_MAX, 8'hFF);
    push_lookup(KEY_MIN);
    push_lookup(KEY_MAX - 1);
    push_lookup(KEY_MAX);
    push_assign(-100, 100, 8'h00);
    push_lookup(-101);
    push_lookup(-100);
    push_lookup(99);
    push_lookup(100);
    push_assign(-50, 50, 8'hFF);
    push_assign(KEY_MIN, 0, 8'h5A);
    push_assign(0, 10, 8'd7);
    push_assign(10, 20, 8'd7);
    push_assign(-5, 25, 8'd7);
    push_lookup(-1);
    push_lookup(15);
    push_lookup(0);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: write_default(8'h00);
        1: write_default(8'hFF);
        default: write_default(val_t'($urandom_range(0, 255)));
      endcase
      idle_on = (p != 0 && p != 5);
      case ($urandom_range(0, 4))
        0: wnd = 4;
        1: wnd = 16;
        2: wnd = 64;
        3: wnd = 300;
        default: wnd = 5000;
      endcase
      if (p == 2 || p == 9) hold_requests++;
      k = 0;
      if (p % 3 == 1) begin
        // Clear, then lay down disjoint one-key ranges until the table overflows.
        push_assign(KEY_MIN, KEY_MAX, dflt_value);
        base = int'($urandom_range(0, 400)) - 200;
        stride = $urandom_range(2, 4);
        for (k = 1; k <= FILL_ITEMS; k++)
          push_assign(base + k * stride, base + k * stride + 1,
                      dflt_value ^ val_t'(1 + k % 5));
        k = FILL_ITEMS + 1;
        if (wnd < 100) wnd = 100;
      end
      for (; k < PHASE_ITEMS; k++)
        pending_reqs.push_back(random_req(wnd));
    end

    wait_drained();
    repeat (150) @(posedge clk);
    $display("Covered %0d lookups and %0d assigns under %0d default settings;",
             n_lookup, n_assign, cfg_writes);
    $display("%0d empty ranges, %0d assigns refused on a full table, %0d results checked.",
             n_empty, n_full, results_checked);
    if (err_count == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d requests pending, %0d results outstanding",
             pending_reqs.size(), predicted_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
